// ===== rtl/core/lrup_pkg.sv =====
// shared constants, types and helpers of the lru replacement block
package lrup_pkg;

    localparam int SETS     = 64;
    localparam int WAYS     = 16;
    localparam int STAMP_W  = 64;
    localparam int OP_W     = 2;
    localparam int SET_W    = 6;
    localparam int WAY_W    = 4;
    localparam int MASK_W   = 16;
    localparam int VICTIM_W = 5;
    localparam int SET_AW   = $clog2(SETS);
    localparam int WAY_AW   = $clog2(WAYS);
    localparam int LEVELS   = $clog2(WAYS);
    localparam int ROW_W    = WAYS * STAMP_W;

    typedef enum logic [OP_W-1:0] {
        OP_VICTIM = 2'd0,
        OP_FILL   = 2'd1,
        OP_ACCESS = 2'd2
    } lrup_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_RESULT
    } lrup_state_t;

    // one candidate in the minimum tree
    typedef struct packed {
        logic                 found;
        logic [WAY_AW-1:0]    way;
        logic [STAMP_W-1:0]   stamp;
    } lrup_node_t;

    // status from the tree to the controller
    typedef struct packed {
        logic                 done;
        logic                 found;
        logic [WAY_AW-1:0]    way;
    } lrup_pick_t;

    // lower way (a) wins ties
    function automatic lrup_node_t lrup_min(lrup_node_t a, lrup_node_t b);
        lrup_node_t r;
        if (a.found && (!b.found || (a.stamp <= b.stamp)))
            r = a;
        else
            r = b;
        return r;
    endfunction

endpackage

// ===== rtl/core/lrup_req_if.sv =====
// request channel interface of the lru replacement block
interface lrup_req_if;
    logic                           valid;
    logic                           ready;
    logic [lrup_pkg::OP_W-1:0]      opcode;
    logic [lrup_pkg::SET_W-1:0]     set_index;
    logic [lrup_pkg::WAY_W-1:0]     way_index;
    logic [lrup_pkg::MASK_W-1:0]    pinned_mask;
    logic                           hit;
    logic                           is_write;

    modport source (
        output valid, opcode, set_index, way_index, pinned_mask, hit, is_write,
        input  ready
    );
    modport sink (
        input  valid, opcode, set_index, way_index, pinned_mask, hit, is_write,
        output ready
    );
endinterface

// ===== rtl/core/lrup_res_if.sv =====
// result channel interface of the lru replacement block
interface lrup_res_if;
    logic                           valid;
    logic                           ready;
    logic [lrup_pkg::VICTIM_W-1:0]  victim_way;
    logic                           bypass;

    modport source (
        output valid, victim_way, bypass,
        input  ready
    );
    modport sink (
        input  valid, victim_way, bypass,
        output ready
    );
endinterface

// ===== rtl/core/lru_replacement_with_pinning.sv =====
// top level of the timestamp lru replacement block with pinned ways
//
// channel  dir  payload                                               handshake
// req      in   opcode, set_index, way_index, pinned_mask, hit,      valid/ready
//               is_write
// res      out  victim_way, bypass                                    valid/ready
//
// one request at a time; a victim request goes through accept, the row read from
// the stamp memory, then the levels of the minimum tree in turn. a fill or access
// update goes through accept, then the read-modify-write of the set row; a request
// that changes nothing is done at accept.
// reset clears the counter and one valid bit per set row, an invalid row reads
// as all-zero stamps, so there is no clearing pass.
// the output register lets a new request enter while a result waits; a victim
// result that finds the output register full holds until it is taken.
module lru_replacement_with_pinning (
    input logic       clk,
    input logic       rst_n,
    lrup_req_if.sink  req,
    lrup_res_if.source res
);

    lrup_pkg::lrup_state_t state_reg, state_next;

    // latched request
    logic                          victim_reg;
    logic                          set_ok_reg;
    logic [lrup_pkg::SET_AW-1:0]   set_reg;
    logic [lrup_pkg::WAY_W-1:0]    way_reg;
    logic [lrup_pkg::MASK_W-1:0]   mask_reg;

    // global use counter and per-row valid bits
    logic [lrup_pkg::STAMP_W-1:0]  counter_reg;
    logic [lrup_pkg::SETS-1:0]     row_valid_reg;

    // output register
    logic                          out_valid_reg;
    logic [lrup_pkg::VICTIM_W-1:0] victim_out_reg;
    logic                          bypass_reg;

    // decode and control
    logic                          accept;
    logic                          in_victim;
    logic                          in_touch;
    logic                          in_set_ok;
    logic                          in_way_ok;
    logic                          slot_free;
    logic                          load_out;
    logic                          wr_en;
    logic                          tree_start;

    logic [lrup_pkg::ROW_W-1:0]    rd_row;
    logic [lrup_pkg::ROW_W-1:0]    row_cur;
    logic [lrup_pkg::ROW_W-1:0]    row_wr;
    lrup_pkg::lrup_pick_t          pick;
    logic                          pick_found;
    logic [lrup_pkg::VICTIM_W-1:0] pick_victim;

    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || res.ready;
    assign in_set_ok = (32'(req.set_index) < 32'(lrup_pkg::SETS));
    assign in_way_ok = (32'(req.way_index) < 32'(lrup_pkg::WAYS));

    // opcode decode; unused code does nothing
    always_comb
    begin
        in_victim = 1'b0;
        in_touch  = 1'b0;
        unique case (lrup_pkg::lrup_op_t'(req.opcode))
            lrup_pkg::OP_VICTIM: in_victim = 1'b1;
            lrup_pkg::OP_FILL:   in_touch  = 1'b1;
            lrup_pkg::OP_ACCESS: in_touch  = req.hit && !req.is_write;
            default:             in_touch  = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lrup_pkg::ST_IDLE:
            begin
                if (accept && (in_victim || (in_touch && in_set_ok && in_way_ok)))
                    state_next = lrup_pkg::ST_READ;
            end
            lrup_pkg::ST_READ:
            begin
                state_next = victim_reg ? lrup_pkg::ST_SCAN : lrup_pkg::ST_IDLE;
            end
            lrup_pkg::ST_SCAN:
            begin
                if (pick.done)
                    state_next = slot_free ? lrup_pkg::ST_IDLE : lrup_pkg::ST_RESULT;
            end
            lrup_pkg::ST_RESULT:
            begin
                if (slot_free)
                    state_next = lrup_pkg::ST_IDLE;
            end
            default: state_next = lrup_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready  = 1'b0;
        wr_en      = 1'b0;
        tree_start = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            lrup_pkg::ST_IDLE:   req.ready  = 1'b1;
            lrup_pkg::ST_READ:
            begin
                wr_en      = !victim_reg;
                tree_start = victim_reg;
            end
            lrup_pkg::ST_SCAN:   load_out   = pick.done && slot_free;
            lrup_pkg::ST_RESULT: load_out   = slot_free;
            default:             req.ready  = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lrup_pkg::ST_IDLE;
            counter_reg   <= '0;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                counter_reg            <= counter_reg + 1'b1;
                row_valid_reg[set_reg] <= 1'b1;
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // request payload, held while the request is in flight
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            victim_reg <= in_victim;
            set_ok_reg <= in_set_ok;
            set_reg    <= req.set_index[lrup_pkg::SET_AW-1:0];
            way_reg    <= req.way_index;
            mask_reg   <= req.pinned_mask;
        end
        if (load_out)
        begin
            victim_out_reg <= pick_victim;
            bypass_reg     <= !pick_found;
        end
    end

    // never-written rows read as zero stamps
    assign row_cur = row_valid_reg[set_reg] ? rd_row : '0;

    // stamp the touched way with the counter
    always_comb
    begin
        row_wr = row_cur;
        for (int w = 0; w < lrup_pkg::WAYS; w++)
        begin
            if (32'(way_reg) == w)
                row_wr[w*lrup_pkg::STAMP_W +: lrup_pkg::STAMP_W] = counter_reg;
        end
    end

    // out-of-range set answers bypass
    assign pick_found  = pick.found && set_ok_reg;
    assign pick_victim = pick_found ? lrup_pkg::VICTIM_W'(pick.way)
                                    : lrup_pkg::VICTIM_W'(lrup_pkg::WAYS);

    lrup_ram #(
        .WIDTH (lrup_pkg::ROW_W),
        .DEPTH (lrup_pkg::SETS)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (set_reg),
        .wr_data (row_wr),
        .rd_en   (accept),
        .rd_addr (req.set_index[lrup_pkg::SET_AW-1:0]),
        .rd_data (rd_row)
    );

    lrup_victim_tree u_tree (
        .clk   (clk),
        .rst_n (rst_n),
        .start (tree_start),
        .row   (row_cur),
        .mask  (mask_reg),
        .pick  (pick)
    );

    assign res.valid      = out_valid_reg;
    assign res.victim_way = victim_out_reg;
    assign res.bypass     = bypass_reg;

    // every row write advances the counter by exactly one
    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (counter_reg == $past(counter_reg) + 1'b1))
        else $error("use counter did not advance on a stamp write");

    // tree latency must line up with the scan state
    a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pick.done |-> (state_reg == lrup_pkg::ST_SCAN))
        else $error("tree result arrived outside the scan state");

    // bypass flag agrees with the victim code
    a_bypass_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (bypass_reg == (victim_out_reg == lrup_pkg::VICTIM_W'(lrup_pkg::WAYS))))
        else $error("bypass flag disagrees with victim way");

    // an accepted victim request always starts a row read
    a_victim_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_victim) |=> (state_reg == lrup_pkg::ST_READ))
        else $error("victim request did not start a row read");

endmodule

// ===== rtl/core/lrup_ram.sv =====
// generic single write port, single read port ram with registered read
module lrup_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/lrup_victim_tree.sv =====
// registered minimum tree over the stamps of one set row
module lrup_victim_tree (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [lrup_pkg::ROW_W-1:0]  row,
    input  logic [lrup_pkg::MASK_W-1:0] mask,
    output lrup_pkg::lrup_pick_t        pick
);

    // heap layout: node 1 is the root, leaves sit at WAYS .. 2*WAYS-1
    lrup_pkg::lrup_node_t all_nodes [1:2*lrup_pkg::WAYS-1];
    lrup_pkg::lrup_node_t node_reg  [1:lrup_pkg::WAYS-1];
    lrup_pkg::lrup_node_t node_next [1:lrup_pkg::WAYS-1];
    logic [lrup_pkg::LEVELS-1:0] done_reg;

    always_comb
    begin
        for (int w = 0; w < lrup_pkg::WAYS; w++)
        begin
            all_nodes[lrup_pkg::WAYS + w].found =
                (w < lrup_pkg::MASK_W) ? !mask[w % lrup_pkg::MASK_W] : 1'b1;
            all_nodes[lrup_pkg::WAYS + w].way   = lrup_pkg::WAY_AW'(w);
            all_nodes[lrup_pkg::WAYS + w].stamp = row[w*lrup_pkg::STAMP_W +: lrup_pkg::STAMP_W];
        end
        for (int i = 1; i < lrup_pkg::WAYS; i++)
        begin
            all_nodes[i] = node_reg[i];
        end
    end

    always_comb
    begin
        for (int i = 1; i < lrup_pkg::WAYS; i++)
        begin
            node_next[i] = lrup_pkg::lrup_min(all_nodes[2*i], all_nodes[2*i+1]);
        end
    end

    // free running; one level settles per cycle while the inputs hold
    always_ff @(posedge clk)
    begin
        for (int i = 1; i < lrup_pkg::WAYS; i++)
        begin
            node_reg[i] <= node_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
        end
        else
        begin
            done_reg <= (done_reg << 1) | lrup_pkg::LEVELS'(start);
        end
    end

    assign pick.done  = done_reg[lrup_pkg::LEVELS-1];
    assign pick.found = node_reg[1].found;
    assign pick.way   = node_reg[1].way;

endmodule

// ===== test/tb_top.sv =====
// testbench of the lru replacement block: directed table, random requests, predictor check
`timescale 1ns / 1ps

module tb_top;
    import lrup_pkg::*;

    // opcode encoding left unused by the block, must change nothing
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 1100;
    localparam int IDLE_PERCENT  = 29;
    // the receiver hold-off starts at this random request and lasts this many cycles
    localparam int HOLD_OFF_AT   = 200;
    localparam int HOLD_OFF_LEN  = 300;
    // requests in this window go out back to back and their results are taken at once
    localparam int QUIET_FIRST   = 600;
    localparam int QUIET_LAST    = 799;
    // this is ample to catch stray results after the last owed victim result
    localparam int DRAIN_CYCLES  = 16;
    // longest legal run without any handshake is the hold-off plus some idles
    localparam int STALL_LIMIT   = 2000;
    localparam int SHOWN_ERRORS  = 10;

    // one request as it goes over the request channel
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [SET_W-1:0]  set_i;
        logic [WAY_W-1:0]  way_i;
        logic [MASK_W-1:0] mask;
        logic              hit;
        logic              wr;
    } req_item_t;

    // one victim decision as it comes back on the result channel
    typedef struct packed {
        logic [VICTIM_W-1:0] way;
        logic                bypass;
    } victim_pick_t;

    // a directed row, with the answer typed in where it is obvious
    typedef struct packed {
        req_item_t    item;
        logic         typed;
        victim_pick_t want;
    } probe_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lrup_req_if req_ch ();
    lrup_res_if res_ch ();

    lru_replacement_with_pinning u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #6 clk = ~clk;

    // predictor state: last-use stamp of every way and the global use counter
    logic [STAMP_W-1:0] last_use [SETS][WAYS];
    logic [STAMP_W-1:0] use_count;

    // victim decisions still owed by the block, oldest first
    victim_pick_t pending_victims[$];
    // one note per offered request: typed answer or not, in offer order
    probe_row_t   offered_notes[$];
    probe_row_t   probe_table[$];

    bit quiet_stretch = 1'b0;
    bit hold_off_now  = 1'b0;

    int mismatches   = 0;
    int victims_seen = 0;
    int bypass_seen  = 0;
    int touches      = 0;
    int no_effect    = 0;
    int results_seen = 0;

    // lowest stamp among unpinned ways, ties to the lowest way, all pinned gives bypass
    function automatic victim_pick_t choose_victim(logic [SET_W-1:0] set_i,
                                                   logic [MASK_W-1:0] mask);
        victim_pick_t       pick;
        bit                 found;
        bit                 pinned;
        logic [STAMP_W-1:0] best;
        int                 low_way;
        found   = 1'b0;
        best    = '0;
        low_way = WAYS;
        if (int'(set_i) < SETS)
        begin
            for (int w = 0; w < WAYS; w++)
            begin
                // ways past the mask width have no pin bit
                pinned = (w < MASK_W) ? mask[w] : 1'b0;
                if (!pinned && (!found || last_use[set_i][w] < best))
                begin
                    found   = 1'b1;
                    best    = last_use[set_i][w];
                    low_way = w;
                end
            end
        end
        pick.way    = VICTIM_W'(low_way);
        pick.bypass = (low_way == WAYS);
        return pick;
    endfunction

    // stamp a way with the counter, then advance it; out of range does nothing
    function automatic void stamp_way(logic [SET_W-1:0] set_i, logic [WAY_W-1:0] way_i);
        if (int'(set_i) < SETS && int'(way_i) < WAYS)
        begin
            last_use[set_i][way_i] = use_count;
            use_count = use_count + 1'b1;
            touches++;
        end
        else
            no_effect++;
    endfunction

    function automatic void add_row(logic [OP_W-1:0] op, int set_i, int way_i, int mask,
                                    bit hit, bit wr, bit typed = 1'b0,
                                    int want_way = 0, bit want_bypass = 1'b0);
        probe_row_t row;
        row.item.op    = op;
        row.item.set_i = SET_W'(set_i);
        row.item.way_i = WAY_W'(way_i);
        row.item.mask  = MASK_W'(mask);
        row.item.hit   = hit;
        row.item.wr    = wr;
        row.typed      = typed;
        row.want.way   = VICTIM_W'(want_way);
        row.want.bypass = want_bypass;
        probe_table.push_back(row);
    endfunction

    // random request: mostly a few hot sets so that stamps pile up and differ
    function automatic req_item_t random_item();
        req_item_t it;
        int        r;
        it.set_i = ($urandom_range(99) < 70) ? SET_W'($urandom_range(3) * 21)
                                             : SET_W'($urandom_range(SETS - 1));
        r = $urandom_range(99);
        if (r < 35)
            it.op = OP_VICTIM;
        else if (r < 60)
            it.op = OP_FILL;
        else if (r < 93)
            it.op = OP_ACCESS;
        else
            it.op = OP_SPARE;
        it.way_i = WAY_W'($urandom_range(WAYS - 1));
        it.hit   = ($urandom_range(99) < 75);
        it.wr    = ($urandom_range(99) < 25);
        r = $urandom_range(99);
        // pin patterns from none to all, with single-survivor cases in between
        if (r < 20)
            it.mask = '0;
        else if (r < 55)
            it.mask = MASK_W'($urandom());
        else if (r < 63)
            it.mask = '1;
        else if (r < 78)
            it.mask = ~(MASK_W'(1) << $urandom_range(MASK_W - 1));
        else if (r < 88)
            it.mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
        else
            it.mask = MASK_W'($urandom() & $urandom());
        return it;
    endfunction

    // offer one request, idling first at random, and return at its handshake edge
    task automatic send_request(input req_item_t it, input bit typed, input victim_pick_t want);
        probe_row_t note;
        while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT)
        begin
            req_ch.valid <= 1'b0;
            req_ch.pinned_mask <= MASK_W'($urandom());
            @(posedge clk);
        end
        note.item  = it;
        note.typed = typed;
        note.want  = want;
        offered_notes.push_back(note);
        req_ch.valid       <= 1'b1;
        req_ch.opcode      <= it.op;
        req_ch.set_index   <= it.set_i;
        req_ch.way_index   <= it.way_i;
        req_ch.pinned_mask <= it.mask;
        req_ch.hit         <= it.hit;
        req_ch.is_write    <= it.wr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // result side: random stalls, one long hold-off that backs the block up,
    // and no stalls at all during the quiet window
    initial
    begin : result_ready_drive
        bit hold_off_done;
        hold_off_done = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_off_now && !hold_off_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_LEN)
                    @(posedge clk);
                hold_off_done = 1'b1;
            end
            else
            begin
                res_ch.ready <= quiet_stretch || ($urandom_range(99) >= IDLE_PERCENT);
                @(posedge clk);
            end
        end
    end

    // scoreboard: predicts on every accepted request, checks every accepted result
    always @(posedge clk)
    begin : scoreboard
        req_item_t    seen;
        probe_row_t   note;
        victim_pick_t want;
        victim_pick_t got;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.way    = res_ch.victim_way;
                got.bypass = res_ch.bypass;
                results_seen++;
                if (pending_victims.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS)
                        $display("[%0t] unexpected result: victim_way=%0d bypass=%0d",
                                 $time, got.way, got.bypass);
                end
                else
                begin
                    want = pending_victims.pop_front();
                    if (got.way !== want.way || got.bypass !== want.bypass)
                    begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS)
                            $display({"[%0t] mismatch: victim_way exp %0d got %0d,",
                                      " bypass exp %0d got %0d"},
                                     $time, want.way, got.way, want.bypass, got.bypass);
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                seen.op    = req_ch.opcode;
                seen.set_i = req_ch.set_index;
                seen.way_i = req_ch.way_index;
                seen.mask  = req_ch.pinned_mask;
                seen.hit   = req_ch.hit;
                seen.wr    = req_ch.is_write;
                note = offered_notes.pop_front();
                if (seen.op == OP_VICTIM)
                begin
                    want = note.typed ? note.want : choose_victim(seen.set_i, seen.mask);
                    pending_victims.push_back(want);
                    victims_seen++;
                    if (want.bypass)
                        bypass_seen++;
                end
                else if (seen.op == OP_FILL)
                    stamp_way(seen.set_i, seen.way_i);
                else if (seen.op == OP_ACCESS && seen.hit && !seen.wr)
                    stamp_way(seen.set_i, seen.way_i);
                else
                    // misses, writebacks and the spare opcode leave the state alone
                    no_effect++;
            end
        end
    end

    // watchdog: too long without any handshake on either channel ends the run
    initial
    begin : watchdog
        int stalled;
        stalled = 0;
        wait (rst_n);
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                stalled = 0;
            else
                stalled++;
        end
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending_victims.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : stimulus
        req_item_t    it;
        victim_pick_t none;
        none = '0;
        req_ch.valid       <= 1'b0;
        req_ch.opcode      <= OP_VICTIM;
        req_ch.set_index   <= '0;
        req_ch.way_index   <= '0;
        req_ch.pinned_mask <= '0;
        req_ch.hit         <= 1'b0;
        req_ch.is_write    <= 1'b0;
        use_count = '0;
        foreach (last_use[s, w])
            last_use[s][w] = '0;

        // after reset every stamp is zero, so ties go to the lowest unpinned way
        add_row(OP_VICTIM, 0,  0,  'h0000, 0, 0, 1'b1, 0,  1'b0);
        // every way pinned means bypass, reported as way 16
        add_row(OP_VICTIM, 63, 0,  'hFFFF, 0, 0, 1'b1, 16, 1'b1);
        // only the top way left, then only the bottom way left
        add_row(OP_VICTIM, 0,  0,  'h7FFF, 0, 0, 1'b1, 15, 1'b0);
        add_row(OP_VICTIM, 63, 15, 'hFFFE, 1, 1, 1'b1, 0,  1'b0);
        add_row(OP_FILL,   63, 15, 'hFFFF, 1, 1);
        add_row(OP_FILL,   0,  0,  'h0000, 0, 0);
        add_row(OP_VICTIM, 0,  0,  'h0000, 0, 0);
        // access update: only a read hit stamps the way
        add_row(OP_ACCESS, 0,  1,  'h0000, 1, 0);
        add_row(OP_ACCESS, 0,  2,  'h0000, 0, 0);
        add_row(OP_ACCESS, 0,  2,  'h0000, 1, 1);
        add_row(OP_ACCESS, 0,  2,  'hFFFF, 0, 1);
        add_row(OP_VICTIM, 0,  0,  'h0000, 0, 0);
        // spare opcode changes nothing and gives no result
        add_row(OP_SPARE,  0,  2,  'hFFFF, 1, 0);
        add_row(OP_SPARE,  63, 15, 'h0000, 0, 1);
        add_row(OP_VICTIM, 0,  0,  'h0003, 0, 0);
        add_row(OP_FILL,   0,  15, 'h0000, 1, 0);
        add_row(OP_FILL,   0,  2,  'h0000, 0, 1);
        add_row(OP_VICTIM, 0,  0,  'h0000, 0, 0);
        add_row(OP_VICTIM, 0,  0,  'hFFFF, 0, 0, 1'b1, 16, 1'b1);
        // the one unpinned way of set 63 is stamped but still the only choice
        add_row(OP_VICTIM, 63, 0,  'h7FFF, 0, 0, 1'b1, 15, 1'b0);
        add_row(OP_VICTIM, 63, 0,  'h8000, 0, 0);
        add_row(OP_ACCESS, 63, 0,  'h0000, 1, 0);
        add_row(OP_VICTIM, 63, 0,  'h0000, 1, 1);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (probe_table[i])
            send_request(probe_table[i].item, probe_table[i].typed, probe_table[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == HOLD_OFF_AT)
                hold_off_now = 1'b1;
            quiet_stretch = (n >= QUIET_FIRST && n <= QUIET_LAST);
            it = random_item();
            send_request(it, 1'b0, none);
        end
        req_ch.valid <= 1'b0;
        quiet_stretch = 1'b0;

        // let the last accepted request reach the scoreboard, then drain
        @(posedge clk);
        while (pending_victims.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d requests: %0d victim picks (%0d bypass), %0d stamp updates,",
                 probe_table.size() + RANDOM_ITEMS, victims_seen, bypass_seen, touches);
        $display("%0d requests with no effect, %0d results checked, %0d mismatches",
                 no_effect, results_seen, mismatches);
        if (mismatches == 0 && pending_victims.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== lru_replacement_with_pinning.f =====
rtl/core/lrup_pkg.sv
rtl/core/lrup_req_if.sv
rtl/core/lrup_res_if.sv
rtl/core/lrup_ram.sv
rtl/core/lrup_victim_tree.sv
rtl/core/lru_replacement_with_pinning.sv
test/tb_top.sv
